### rtl/stvt_pkg.sv
// Package for the style interval table: sizes, operation codes, cell control.
package stvt_pkg;

	localparam int CAPACITY   = 32;
	localparam int POS_BITS   = 24;
	localparam int STYLE_BITS = 4;

	typedef enum logic [1:0] {
		OP_APPLY = 2'd0,
		OP_QUERY = 2'd1,
		OP_SHIFT = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_SAT  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CC_HOLD   = 3'd0,
		CC_APPLY  = 3'd1,
		CC_SHIFT  = 3'd2,
		CC_PACK   = 3'd3,
		CC_INSERT = 3'd4
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t cmd;
		logic      neg;
	} cell_ctl_t;

endpackage

### rtl/style_interval_table.sv
// Top level of the style interval table: sequencer over a row of entry cells.
//
//   channel | signals                                      | direction
//   in      | in_valid, in_ready, operation, position,     | beat in
//           | length, style, delta                         |
//   out     | out_valid, out_ready, style_found, status,   | beat out
//           | entry_total                                  |
//
// Query and clear go from the edit state straight to the done state. Apply and
// shift also pass the pack state, which drops one removed entry per step (the
// pack-down of the cell row); apply next inserts the split fragment, if any,
// and the new entry unless its style is zero, one per step. The next beat can
// be accepted in the cycle after the result is loaded. One item is in work at
// a time; a result waiting in the output register does not block the next
// accept, but a finished item waits for it to drain. Reset empties the table.
module style_interval_table #(
	parameter int CAPACITY   = stvt_pkg::CAPACITY,
	parameter int POS_BITS   = stvt_pkg::POS_BITS,
	parameter int STYLE_BITS = stvt_pkg::STYLE_BITS,
	parameter int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            operation,
	input  logic [POS_BITS-1:0]   position,
	input  logic [POS_BITS-1:0]   length,
	input  logic [STYLE_BITS-1:0] style,
	input  logic [POS_BITS:0]     delta,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [STYLE_BITS-1:0] style_found,
	output logic [1:0]            status,
	output logic [CNT_W-1:0]      entry_total
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_EDIT = 6'b000010,
		ST_PACK = 6'b000100,
		ST_FRAG = 6'b001000,
		ST_NEW  = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	localparam logic [POS_BITS:0] MAX_W = {1'b0, {POS_BITS{1'b1}}};

	state_t                state_q;
	stvt_pkg::op_t         op_q;
	logic [POS_BITS-1:0]   pos_q, len_q, bound_q, frag_start_q, frag_stop_q;
	logic [STYLE_BITS-1:0] sty_q, frag_style_q, found_q;
	logic [POS_BITS:0]     mag_q;
	logic [POS_BITS+1:0]   cut_q;
	logic                  neg_q, sat_q, full_q, split_q;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;
	logic [STYLE_BITS-1:0] out_found_q;
	logic [1:0]            out_status_q;
	logic [CNT_W-1:0]      out_total_q;

	logic [POS_BITS:0]     sum_w, mag_w;
	logic                  accept, room, load;
	stvt_pkg::cell_ctl_t   ctl;
	logic [POS_BITS-1:0]   key, n_start, n_stop;
	logic [STYLE_BITS-1:0] n_style;

	logic [POS_BITS-1:0]   c_start [CAPACITY];
	logic [POS_BITS-1:0]   c_stop  [CAPACITY];
	logic [STYLE_BITS-1:0] c_style [CAPACITY];
	logic                  c_dead  [CAPACITY];
	logic                  c_chain [CAPACITY];
	logic                  c_sel   [CAPACITY];
	logic                  c_split [CAPACITY];
	logic [POS_BITS-1:0]   c_sstop [CAPACITY];
	logic [STYLE_BITS-1:0] c_ssty  [CAPACITY];
	logic                  c_sat   [CAPACITY];
	logic [STYLE_BITS-1:0] c_hit   [CAPACITY];

	logic                  any_split, any_sat, any_dead;
	logic [POS_BITS-1:0]   split_stop;
	logic [STYLE_BITS-1:0] split_style, hit;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign room     = count_q < CNT_W'(CAPACITY);
	assign load     = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign sum_w    = {1'b0, position} + {1'b0, length};
	assign mag_w    = delta[POS_BITS] ? (~delta + 1'b1) : delta;
	assign any_dead = c_chain[CAPACITY-1];

	always_comb begin
		any_split   = 1'b0;
		any_sat     = 1'b0;
		split_stop  = '0;
		split_style = '0;
		hit         = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			any_split   = any_split | c_split[i];
			any_sat     = any_sat | c_sat[i];
			split_stop  = split_stop | c_sstop[i];
			split_style = split_style | c_ssty[i];
			hit         = hit | c_hit[i];
		end
	end

	always_comb begin
		ctl.cmd = stvt_pkg::CC_HOLD;
		ctl.neg = neg_q;
		key     = pos_q;
		n_start = pos_q;
		n_stop  = bound_q;
		n_style = sty_q;
		case (state_q)
			ST_EDIT: begin
				if (op_q == stvt_pkg::OP_APPLY && len_q != '0 && bound_q > pos_q) begin
					ctl.cmd = stvt_pkg::CC_APPLY;
				end else if (op_q == stvt_pkg::OP_SHIFT && mag_q != '0) begin
					ctl.cmd = stvt_pkg::CC_SHIFT;
				end
			end
			ST_PACK: if (any_dead) ctl.cmd = stvt_pkg::CC_PACK;
			ST_FRAG: begin
				if (room) ctl.cmd = stvt_pkg::CC_INSERT;
				key     = frag_start_q;
				n_start = frag_start_q;
				n_stop  = frag_stop_q;
				n_style = frag_style_q;
			end
			ST_NEW: if (room) ctl.cmd = stvt_pkg::CC_INSERT;
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [POS_BITS-1:0]   p_start, p_stop, x_start, x_stop;
		logic [STYLE_BITS-1:0] p_style, x_style;
		logic                  p_sel, p_chain, x_dead;
		if (i == 0) begin : g_first
			assign p_start = '0;
			assign p_stop  = '0;
			assign p_style = '0;
			assign p_sel   = 1'b0;
			assign p_chain = 1'b0;
		end else begin : g_mid
			assign p_start = c_start[i-1];
			assign p_stop  = c_stop[i-1];
			assign p_style = c_style[i-1];
			assign p_sel   = c_sel[i-1];
			assign p_chain = c_chain[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign x_start = '0;
			assign x_stop  = '0;
			assign x_style = '0;
			assign x_dead  = 1'b0;
		end else begin : g_inner
			assign x_start = c_start[i+1];
			assign x_stop  = c_stop[i+1];
			assign x_style = c_style[i+1];
			assign x_dead  = c_dead[i+1];
		end
		stvt_cell #(
			.POS_BITS(POS_BITS), .STYLE_BITS(STYLE_BITS), .CNT_W(CNT_W), .IDX(i)
		) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl), .count(count_q),
			.pos(pos_q), .bound(bound_q), .mag(mag_q), .cut_stop(cut_q), .key(key),
			.new_start(n_start), .new_stop(n_stop), .new_style(n_style),
			.prev_start(p_start), .prev_stop(p_stop), .prev_style(p_style),
			.prev_sel(p_sel), .dead_in(p_chain),
			.next_start(x_start), .next_stop(x_stop), .next_style(x_style),
			.next_dead(x_dead),
			.start(c_start[i]), .stop(c_stop[i]), .style(c_style[i]),
			.dead_out(c_dead[i]), .dead_chain(c_chain[i]), .sel(c_sel[i]),
			.split(c_split[i]), .split_stop(c_sstop[i]), .split_style(c_ssty[i]),
			.sat(c_sat[i]), .hit_style(c_hit[i])
		);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= stvt_pkg::op_t'(operation);
			pos_q   <= position;
			len_q   <= length;
			sty_q   <= style;
			bound_q <= (sum_w > MAX_W) ? {POS_BITS{1'b1}} : sum_w[POS_BITS-1:0];
			neg_q   <= delta[POS_BITS];
			mag_q   <= mag_w;
			cut_q   <= {2'b00, position} + {1'b0, mag_w};
		end
		if (state_q == ST_EDIT) begin
			frag_start_q <= bound_q;
			frag_stop_q  <= split_stop;
			frag_style_q <= split_style;
		end
		if (load) begin
			out_found_q  <= found_q;
			out_status_q <= full_q ? stvt_pkg::STAT_FULL :
				(sat_q ? stvt_pkg::STAT_SAT : stvt_pkg::STAT_OK);
			out_total_q  <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sat_q       <= 1'b0;
			full_q      <= 1'b0;
			split_q     <= 1'b0;
			found_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EDIT;
						sat_q   <= (operation == stvt_pkg::OP_APPLY) && (sum_w > MAX_W)
							&& (length != '0);
						full_q  <= 1'b0;
						split_q <= 1'b0;
						found_q <= '0;
					end
				end
				ST_EDIT: begin
					case (ctl.cmd)
						stvt_pkg::CC_APPLY: begin
							split_q <= any_split;
							state_q <= ST_PACK;
						end
						stvt_pkg::CC_SHIFT: begin
							sat_q   <= any_sat;
							state_q <= ST_PACK;
						end
						default: begin
							if (op_q == stvt_pkg::OP_QUERY) found_q <= hit;
							if (op_q == stvt_pkg::OP_CLEAR) count_q <= '0;
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_PACK: begin
					if (any_dead) begin
						count_q <= count_q - 1'b1;
					end else if (op_q != stvt_pkg::OP_APPLY) begin
						state_q <= ST_DONE;
					end else if (split_q) begin
						state_q <= ST_FRAG;
					end else if (sty_q != '0) begin
						state_q <= ST_NEW;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_FRAG: begin
					if (room) count_q <= count_q + 1'b1;
					else full_q <= 1'b1;
					state_q <= (sty_q != '0) ? ST_NEW : ST_DONE;
				end
				ST_NEW: begin
					if (room) count_q <= count_q + 1'b1;
					else full_q <= 1'b1;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign style_found = out_found_q;
	assign status      = out_status_q;
	assign entry_total = out_total_q;

`ifndef ASSERT_OFF
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");
	a_pack_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PACK && any_dead) |=> count_q == $past(count_q) - 1'b1)
		else $error("pack step did not drop one entry");
	a_ins_inc: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_NEW || state_q == ST_FRAG) && room)
		|=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not add one entry");
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(load && op_q != stvt_pkg::OP_QUERY) |=> style_found == '0)
		else $error("style reported for a non-query beat");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");
`endif

endmodule

### rtl/stvt_cell.sv
// One table entry: trims, shifts, packs down and makes room for inserts.
module stvt_cell #(
	parameter int POS_BITS   = stvt_pkg::POS_BITS,
	parameter int STYLE_BITS = stvt_pkg::STYLE_BITS,
	parameter int CNT_W      = 6,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stvt_pkg::cell_ctl_t   ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [POS_BITS-1:0]   pos,
	input  logic [POS_BITS-1:0]   bound,
	input  logic [POS_BITS:0]     mag,
	input  logic [POS_BITS+1:0]   cut_stop,
	input  logic [POS_BITS-1:0]   key,
	input  logic [POS_BITS-1:0]   new_start,
	input  logic [POS_BITS-1:0]   new_stop,
	input  logic [STYLE_BITS-1:0] new_style,
	input  logic [POS_BITS-1:0]   prev_start,
	input  logic [POS_BITS-1:0]   prev_stop,
	input  logic [STYLE_BITS-1:0] prev_style,
	input  logic                  prev_sel,
	input  logic                  dead_in,
	input  logic [POS_BITS-1:0]   next_start,
	input  logic [POS_BITS-1:0]   next_stop,
	input  logic [STYLE_BITS-1:0] next_style,
	input  logic                  next_dead,
	output logic [POS_BITS-1:0]   start,
	output logic [POS_BITS-1:0]   stop,
	output logic [STYLE_BITS-1:0] style,
	output logic                  dead_out,
	output logic                  dead_chain,
	output logic                  sel,
	output logic                  split,
	output logic [POS_BITS-1:0]   split_stop,
	output logic [STYLE_BITS-1:0] split_style,
	output logic                  sat,
	output logic [STYLE_BITS-1:0] hit_style
);

	localparam logic [POS_BITS+1:0] MAX_X = {2'b00, {POS_BITS{1'b1}}};

	logic [POS_BITS-1:0]   start_q, stop_q;
	logic [STYLE_BITS-1:0] style_q;
	logic                  dead_q;
	logic                  occ, overlap;
	logic [POS_BITS+1:0]   s_x, e_x, s_sum, e_sum;
	logic [POS_BITS-1:0]   ns, ne;
	logic                  sh_sat;

	assign occ     = count > CNT_W'(IDX);
	assign overlap = occ && (stop_q > pos) && (start_q < bound);

	always_comb begin
		s_x    = {2'b00, start_q};
		e_x    = {2'b00, stop_q};
		s_sum  = s_x + {1'b0, mag};
		e_sum  = e_x + {1'b0, mag};
		ns     = start_q;
		ne     = stop_q;
		sh_sat = 1'b0;
		if (!ctl.neg) begin
			if (start_q >= pos) begin
				if (s_sum > MAX_X) begin
					ns     = {POS_BITS{1'b1}};
					sh_sat = 1'b1;
				end else begin
					ns = s_sum[POS_BITS-1:0];
				end
			end
			if (stop_q > pos) begin
				if (e_sum > MAX_X) begin
					ne     = {POS_BITS{1'b1}};
					sh_sat = 1'b1;
				end else begin
					ne = e_sum[POS_BITS-1:0];
				end
			end
		end else begin
			if (s_x >= cut_stop) begin
				ns = POS_BITS'(s_x - {1'b0, mag});
				ne = POS_BITS'(e_x - {1'b0, mag});
			end else if (stop_q > pos) begin
				ns = (start_q < pos) ? start_q : pos;
				ne = (e_x > cut_stop) ? POS_BITS'(e_x - {1'b0, mag}) : pos;
			end
		end
	end

	assign dead_out    = occ && dead_q;
	assign dead_chain  = dead_in || dead_out;
	assign sel         = (occ && (start_q >= key)) || (count == CNT_W'(IDX));
	assign split       = overlap && (start_q < pos) && (stop_q > bound);
	assign split_stop  = split ? stop_q : '0;
	assign split_style = split ? style_q : '0;
	assign sat         = occ && sh_sat;
	assign hit_style   = (occ && (pos >= start_q) && (pos < stop_q)) ? style_q : '0;
	assign start       = start_q;
	assign stop        = stop_q;
	assign style       = style_q;

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			stvt_pkg::CC_APPLY: begin
				if (overlap) begin
					if (start_q < pos) begin
						stop_q <= pos;
					end else if (stop_q > bound) begin
						start_q <= bound;
					end
				end
			end
			stvt_pkg::CC_SHIFT: begin
				if (occ) begin
					start_q <= ns;
					stop_q  <= ne;
				end
			end
			stvt_pkg::CC_PACK: begin
				if (dead_chain) begin
					start_q <= next_start;
					stop_q  <= next_stop;
					style_q <= next_style;
				end
			end
			stvt_pkg::CC_INSERT: begin
				if (sel) begin
					if (prev_sel) begin
						start_q <= prev_start;
						stop_q  <= prev_stop;
						style_q <= prev_style;
					end else begin
						start_q <= new_start;
						stop_q  <= new_stop;
						style_q <= new_style;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q <= 1'b0;
		end else begin
			case (ctl.cmd)
				stvt_pkg::CC_APPLY:  dead_q <= overlap && (start_q >= pos) && (stop_q <= bound);
				stvt_pkg::CC_SHIFT:  dead_q <= occ && (ne <= ns);
				stvt_pkg::CC_PACK:   if (dead_chain) dead_q <= next_dead;
				stvt_pkg::CC_INSERT: if (sel) dead_q <= 1'b0;
				default: begin
				end
			endcase
		end
	end

endmodule
